>>> src/vpss_pkg.sv
// Package with the shared types, widths and constants of the Verlet particle stick solver.
package vpss_pkg;

	// Field widths of the transactions.
	localparam int CMD_W    = 2;
	localparam int IDX_W    = 11;
	localparam int POS_W    = 24;
	localparam int DT_W     = 16;
	localparam int LEN_W    = 23;
	localparam int K_W      = 16;
	localparam int STATUS_W = 2;

	// Fixed point format and defaults.
	localparam int FRAC_BITS          = 8;
	localparam int PARTICLE_COUNT_DEF = 2048;
	localparam int LOAD_NUDGE         = ((1 << FRAC_BITS) + 5) / 10;
	localparam int FLOOR_Y_RESET      = 720 * (1 << FRAC_BITS);
	localparam int POS_MAX            = (1 << (POS_W - 1)) - 1;
	localparam int POS_MIN            = -(1 << (POS_W - 1));

	// Internal datapath widths.
	localparam int SUM_W  = POS_W + 4;
	localparam int DX_W   = POS_W + 1;
	localparam int SQ_W   = 2 * DX_W;
	localparam int ROOT_W = SQ_W / 2;
	localparam int DIFF_W = ROOT_W + 1;
	localparam int NUM_W  = SQ_W;
	localparam int Q_W    = ROOT_W;
	localparam int QS_W   = Q_W + 1;
	localparam int TX_W   = POS_W + 1;
	localparam int OFF_W  = QS_W;
	localparam int MUL_W  = 2 * DT_W + 1;
	localparam int PROD_W = 2 * MUL_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD      = 2'd0,
		CMD_INTEGRATE = 2'd1,
		CMD_RELAX     = 2'd2,
		CMD_READ      = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_SAT      = 2'd2
	} status_t;

	typedef logic signed [POS_W-1:0] pos_t;

	// One stored particle.
	typedef struct packed {
		pos_t cur_x;
		pos_t cur_y;
		pos_t old_x;
		pos_t old_y;
		pos_t acc_x;
		pos_t acc_y;
		logic pinned;
		logic bounces;
	} particle_t;

	typedef struct packed {
		logic sat;
		pos_t val;
	} clamp_t;

	// Clamp a wide sum to the position range and flag saturation.
	function automatic clamp_t clamp_pos(input logic signed [SUM_W-1:0] v);
		clamp_t r;
		if (v > SUM_W'(POS_MAX)) begin
			r.sat = 1'b1;
			r.val = POS_W'(POS_MAX);
		end else if (v < SUM_W'(POS_MIN)) begin
			r.sat = 1'b1;
			r.val = POS_W'(POS_MIN);
		end else begin
			r.sat = 1'b0;
			r.val = POS_W'(v);
		end
		return r;
	endfunction

endpackage

>>> src/vpss_if.sv
// Channel interfaces of the solver: command request, result response and floor register write.
interface vpss_req_if import vpss_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        cmd;
	logic [IDX_W-1:0]        index_a;
	logic [IDX_W-1:0]        index_b;
	logic signed [POS_W-1:0] load_x;
	logic signed [POS_W-1:0] load_y;
	logic signed [POS_W-1:0] accel_x;
	logic signed [POS_W-1:0] accel_y;
	logic                    fixed_flag;
	logic                    bounded_flag;
	logic [DT_W-1:0]         time_step;
	logic [LEN_W-1:0]        rest_length;
	logic [K_W-1:0]          stiffness;

	modport source (output valid, cmd, index_a, index_b, load_x, load_y, accel_x, accel_y,
		fixed_flag, bounded_flag, time_step, rest_length, stiffness, input ready);
	modport sink (input valid, cmd, index_a, index_b, load_x, load_y, accel_x, accel_y,
		fixed_flag, bounded_flag, time_step, rest_length, stiffness, output ready);
endinterface

interface vpss_rsp_if import vpss_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [STATUS_W-1:0]     status;

	modport source (output valid, pos_x, pos_y, status, input ready);
	modport sink (input valid, pos_x, pos_y, status, output ready);
endinterface

interface vpss_cfg_if import vpss_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] floor_y;

	modport source (output valid, floor_y, input ready);
	modport sink (input valid, floor_y, output ready);
endinterface

>>> src/vpss_mem.sv
// Particle store: one synchronous memory, one write and one registered read per cycle.
module vpss_mem import vpss_pkg::*; #(
	parameter int DEPTH  = PARTICLE_COUNT_DEF,
	parameter int ADDR_W = $clog2(PARTICLE_COUNT_DEF)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  particle_t         wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output particle_t         rd_data
);

	particle_t mem_q [DEPTH];
	particle_t rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/vpss_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module vpss_sqrt import vpss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W:0]   trial;
	logic            take;

	// Trial subtraction of the current root candidate.
	always_comb begin
		trial = (SQ_W + 1)'(res_q) + (SQ_W + 1)'(bit_q);
		take  = (SQ_W + 1)'(v_q) >= trial;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (take) begin
				v_q   <= SQ_W'((SQ_W + 1)'(v_q) - trial);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];

endmodule

>>> src/vpss_div.sv
// Two-lane restoring divider with a shared divisor, one quotient bit per cycle.
module vpss_div import vpss_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num_x,
	input  logic signed [NUM_W-1:0] num_y,
	input  logic [ROOT_W-1:0]       den,
	output logic                    done,
	output logic signed [QS_W-1:0]  quo_x,
	output logic signed [QS_W-1:0]  quo_y
);

	localparam int CNT_W = $clog2(Q_W);

	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W-1:0] den_q;
	logic [ROOT_W-1:0] rem_x_q, rem_y_q;
	logic [Q_W-1:0]    low_x_q, low_y_q;
	logic              neg_x_q, neg_y_q;
	logic [NUM_W-1:0]  mag_x, mag_y;
	logic [ROOT_W:0]   tx, ty;
	logic              gx, gy;

	// Magnitudes of the dividends and the trial subtractions of both lanes.
	always_comb begin
		mag_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
		mag_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
		tx    = {rem_x_q, low_x_q[Q_W-1]};
		ty    = {rem_y_q, low_y_q[Q_W-1]};
		gx    = tx >= (ROOT_W + 1)'(den_q);
		gy    = ty >= (ROOT_W + 1)'(den_q);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the low register shifts dividend bits out and quotient bits in.
	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= den;
			neg_x_q <= num_x[NUM_W-1];
			neg_y_q <= num_y[NUM_W-1];
			rem_x_q <= mag_x[Q_W+ROOT_W-1:Q_W];
			rem_y_q <= mag_y[Q_W+ROOT_W-1:Q_W];
			low_x_q <= mag_x[Q_W-1:0];
			low_y_q <= mag_y[Q_W-1:0];
		end else if (busy_q) begin
			rem_x_q <= gx ? ROOT_W'(tx - (ROOT_W + 1)'(den_q)) : ROOT_W'(tx);
			rem_y_q <= gy ? ROOT_W'(ty - (ROOT_W + 1)'(den_q)) : ROOT_W'(ty);
			low_x_q <= {low_x_q[Q_W-2:0], gx};
			low_y_q <= {low_y_q[Q_W-2:0], gy};
		end
	end

	assign done  = done_q;
	assign quo_x = neg_x_q ? -$signed({1'b0, low_x_q}) : $signed({1'b0, low_x_q});
	assign quo_y = neg_y_q ? -$signed({1'b0, low_y_q}) : $signed({1'b0, low_y_q});

endmodule

>>> src/verlet_particle_stick_solver_unit.sv
// Top level of the Verlet particle stick solver: command sequencer, shared multiplier and store.
//
// The block keeps PARTICLE_COUNT particles in one synchronous memory and works one command
// at a time, reading and writing the addressed entries as the command needs. An integrate
// makes three passes through the one shared 33x33 multiplier, and the time of a stick relax
// is set by the 25-step square root and the 25-step divider that run one after the other.
// With fewer than 2048 particles the indices are first reduced modulo PARTICLE_COUNT in the
// S_WRAP state, ahead of every command. A new command is taken as soon as the previous one
// has its result in the output register.
module verlet_particle_stick_solver_unit import vpss_pkg::*; #(
	parameter int PARTICLE_COUNT = PARTICLE_COUNT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	vpss_req_if.sink    req,
	vpss_rsp_if.source  rsp,
	vpss_cfg_if.sink    cfg
);

	localparam int ADDR_W = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
	localparam bit WRAP   = PARTICLE_COUNT < (1 << IDX_W);
	localparam int CNT_W  = $clog2(PARTICLE_COUNT + 1);
	localparam int RED_W  = CNT_W + IDX_W;
	localparam int SH_W   = $clog2(IDX_W);

	typedef enum logic [25:0] {
		S_IDLE     = 26'd1 << 0,
		S_WRAP     = 26'd1 << 1,
		S_LOAD     = 26'd1 << 2,
		S_RD_A     = 26'd1 << 3,
		S_GET_A    = 26'd1 << 4,
		S_GET_B    = 26'd1 << 5,
		S_I_DT     = 26'd1 << 6,
		S_I_AX     = 26'd1 << 7,
		S_I_AY     = 26'd1 << 8,
		S_I_NEW    = 26'd1 << 9,
		S_I_WR     = 26'd1 << 10,
		S_R_SQX    = 26'd1 << 11,
		S_R_SQY    = 26'd1 << 12,
		S_R_SQS    = 26'd1 << 13,
		S_R_SQRT   = 26'd1 << 14,
		S_R_DIFF   = 26'd1 << 15,
		S_R_NX     = 26'd1 << 16,
		S_R_NY     = 26'd1 << 17,
		S_R_DSTART = 26'd1 << 18,
		S_R_DIV    = 26'd1 << 19,
		S_R_KX     = 26'd1 << 20,
		S_R_KY     = 26'd1 << 21,
		S_R_OFF    = 26'd1 << 22,
		S_R_WA     = 26'd1 << 23,
		S_R_WB     = 26'd1 << 24,
		S_DONE     = 26'd1 << 25
	} state_t;

	state_t state_q, state_d;

	// Latched command.
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  a_q, b_q;
	pos_t              ld_x_q, ld_y_q, ax_q, ay_q;
	logic              fix_q, bnd_q;
	logic [DT_W-1:0]   dt_q;
	logic [LEN_W-1:0]  len_q;
	logic [K_W-1:0]    k_q;
	logic [SH_W-1:0]   sh_q;

	// Working registers.
	particle_t                wa_q, wb_q;
	logic signed [DX_W-1:0]   dx_q, dy_q;
	logic [2*DT_W-1:0]        dt2_q;
	logic signed [TX_W-1:0]   tx_q;
	pos_t                     nx_q, ny_q;
	logic [SQ_W-1:0]          sq_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [NUM_W-1:0]  numx_q;
	logic signed [OFF_W-1:0]  offx_q, offy_q;
	logic                     sat_q;
	pos_t                     res_x_q, res_y_q;
	status_t                  res_st_q;
	logic signed [PROD_W-1:0] prod_q;
	pos_t                     floor_y_q;

	// Output register.
	logic    out_valid_q;
	pos_t    out_x_q, out_y_q;
	status_t out_st_q;

	// Memory port signals.
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr, addr_a, addr_b;
	particle_t         wr_data, rd_data;

	// Shared multiplier operands.
	logic signed [MUL_W-1:0] mul_a, mul_b;

	// Iterative units.
	logic                    sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]       root;
	logic                    div_start, div_done;
	logic signed [QS_W-1:0]  quo_x, quo_y;

	// Combinational results.
	logic signed [PROD_W-1:0] rnd32, rnd16;
	logic signed [TX_W-1:0]   ty_c;
	logic signed [OFF_W-1:0]  off_c;
	clamp_t                   ld_oy, int_nx, int_ny, bnc_oy, rel_ax, rel_ay, rel_bx, rel_by;
	logic                     bounce;
	logic [RED_W-1:0]         lim_c;
	logic                     red_a, red_b;
	state_t                   dispatch;

	assign addr_a = ADDR_W'(a_q);
	assign addr_b = ADDR_W'(b_q);

	// Rounding, clamping and the index reduction step.
	always_comb begin
		rnd32  = prod_q + (PROD_W'(1) <<< 31);
		rnd16  = prod_q + (PROD_W'(1) <<< 15);
		ty_c   = rnd32[TX_W+31:32];
		off_c  = rnd16[OFF_W+15:16];
		ld_oy  = clamp_pos(SUM_W'(ld_y_q) + SUM_W'(LOAD_NUDGE));
		int_nx = clamp_pos((SUM_W'(wa_q.cur_x) <<< 1) - SUM_W'(wa_q.old_x) + SUM_W'(tx_q));
		int_ny = clamp_pos((SUM_W'(wa_q.cur_y) <<< 1) - SUM_W'(wa_q.old_y) + SUM_W'(ty_c));
		bnc_oy = clamp_pos((SUM_W'(ny_q) <<< 1) - SUM_W'(wa_q.cur_y));
		bounce = wa_q.bounces && (ny_q > floor_y_q);
		rel_ax = clamp_pos(SUM_W'(wa_q.cur_x) - SUM_W'(offx_q));
		rel_ay = clamp_pos(SUM_W'(wa_q.cur_y) - SUM_W'(offy_q));
		rel_bx = clamp_pos(SUM_W'(wb_q.cur_x) + SUM_W'(offx_q));
		rel_by = clamp_pos(SUM_W'(wb_q.cur_y) + SUM_W'(offy_q));
		lim_c  = RED_W'(PARTICLE_COUNT) << sh_q;
		red_a  = RED_W'(a_q) >= lim_c;
		red_b  = RED_W'(b_q) >= lim_c;
		dispatch = (cmd_q == CMD_LOAD) ? S_LOAD : S_RD_A;
	end

	// Multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_I_DT: begin
				mul_a = MUL_W'({1'b0, dt_q});
				mul_b = MUL_W'({1'b0, dt_q});
			end
			S_I_AX: begin
				mul_a = MUL_W'(wa_q.acc_x);
				mul_b = MUL_W'({1'b0, prod_q[2*DT_W-1:0]});
			end
			S_I_AY: begin
				mul_a = MUL_W'(wa_q.acc_y);
				mul_b = MUL_W'({1'b0, dt2_q});
			end
			S_R_SQX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			S_R_SQY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(dy_q);
			end
			S_R_NX: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(diff_q);
			end
			S_R_NY: begin
				mul_a = MUL_W'(dy_q);
				mul_b = MUL_W'(diff_q);
			end
			S_R_KX: begin
				mul_a = MUL_W'(quo_x);
				mul_b = MUL_W'({1'b0, k_q});
			end
			S_R_KY: begin
				mul_a = MUL_W'(quo_y);
				mul_b = MUL_W'({1'b0, k_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Memory access control.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_a;
		wr_data = wa_q;
		rd_en   = 1'b0;
		rd_addr = addr_a;
		unique case (state_q)
			S_LOAD: begin
				wr_en           = 1'b1;
				wr_data.cur_x   = ld_x_q;
				wr_data.cur_y   = ld_y_q;
				wr_data.old_x   = ld_x_q;
				wr_data.old_y   = ld_oy.val;
				wr_data.acc_x   = ax_q;
				wr_data.acc_y   = ay_q;
				wr_data.pinned  = fix_q;
				wr_data.bounces = bnd_q;
			end
			S_RD_A: begin
				rd_en = 1'b1;
			end
			S_GET_A: begin
				rd_en   = 1'b1;
				rd_addr = addr_b;
			end
			S_I_WR: begin
				wr_en         = 1'b1;
				wr_data.cur_x = nx_q;
				wr_data.cur_y = ny_q;
				wr_data.old_x = wa_q.cur_x;
				wr_data.old_y = bounce ? bnc_oy.val : wa_q.cur_y;
			end
			S_R_WA: begin
				wr_en         = !wa_q.pinned;
				wr_data.cur_x = rel_ax.val;
				wr_data.cur_y = rel_ay.val;
			end
			S_R_WB: begin
				wr_en         = !wb_q.pinned;
				wr_addr       = addr_b;
				wr_data       = wb_q;
				wr_data.cur_x = rel_bx.val;
				wr_data.cur_y = rel_by.val;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign sqrt_start = (state_q == S_R_SQS);
	assign div_start  = (state_q == S_R_DSTART);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (WRAP) begin
						state_d = S_WRAP;
					end else begin
						state_d = (cmd_t'(req.cmd) == CMD_LOAD) ? S_LOAD : S_RD_A;
					end
				end
			end
			S_WRAP:     state_d = (sh_q == '0) ? dispatch : S_WRAP;
			S_LOAD:     state_d = S_DONE;
			S_RD_A:     state_d = S_GET_A;
			S_GET_A: begin
				if (cmd_q == CMD_RELAX) begin
					state_d = S_GET_B;
				end else if (cmd_q == CMD_INTEGRATE && !rd_data.pinned) begin
					state_d = S_I_DT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_GET_B:    state_d = S_R_SQX;
			S_I_DT:     state_d = S_I_AX;
			S_I_AX:     state_d = S_I_AY;
			S_I_AY:     state_d = S_I_NEW;
			S_I_NEW:    state_d = S_I_WR;
			S_I_WR:     state_d = S_DONE;
			S_R_SQX:    state_d = S_R_SQY;
			S_R_SQY:    state_d = S_R_SQS;
			S_R_SQS:    state_d = S_R_SQRT;
			S_R_SQRT: begin
				if (sqrt_done) begin
					state_d = (root == '0) ? S_DONE : S_R_DIFF;
				end
			end
			S_R_DIFF:   state_d = S_R_NX;
			S_R_NX:     state_d = S_R_NY;
			S_R_NY:     state_d = S_R_DSTART;
			S_R_DSTART: state_d = S_R_DIV;
			S_R_DIV:    state_d = div_done ? S_R_KX : S_R_DIV;
			S_R_KX:     state_d = S_R_KY;
			S_R_KY:     state_d = S_R_OFF;
			S_R_OFF:    state_d = S_R_WA;
			S_R_WA:     state_d = S_R_WB;
			S_R_WB:     state_d = S_DONE;
			S_DONE:     state_d = (!out_valid_q || rsp.ready) ? S_IDLE : S_DONE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			floor_y_q   <= POS_W'(FLOOR_Y_RESET);
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				floor_y_q <= cfg.floor_y;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					cmd_q  <= cmd_t'(req.cmd);
					a_q    <= req.index_a;
					b_q    <= req.index_b;
					ld_x_q <= req.load_x;
					ld_y_q <= req.load_y;
					ax_q   <= req.accel_x;
					ay_q   <= req.accel_y;
					fix_q  <= req.fixed_flag;
					bnd_q  <= req.bounded_flag;
					dt_q   <= req.time_step;
					len_q  <= req.rest_length;
					k_q    <= req.stiffness;
					sh_q   <= SH_W'(IDX_W - 1);
					sat_q  <= 1'b0;
				end
			end
			S_WRAP: begin
				if (red_a) begin
					a_q <= IDX_W'(RED_W'(a_q) - lim_c);
				end
				if (red_b) begin
					b_q <= IDX_W'(RED_W'(b_q) - lim_c);
				end
				sh_q <= sh_q - 1'b1;
			end
			S_LOAD: begin
				res_x_q  <= ld_x_q;
				res_y_q  <= ld_y_q;
				res_st_q <= ld_oy.sat ? ST_SAT : ST_OK;
			end
			S_GET_A: begin
				wa_q     <= rd_data;
				res_x_q  <= rd_data.cur_x;
				res_y_q  <= rd_data.cur_y;
				res_st_q <= ST_OK;
			end
			S_GET_B: begin
				wb_q <= rd_data;
				dx_q <= DX_W'(rd_data.cur_x) - DX_W'(wa_q.cur_x);
				dy_q <= DX_W'(rd_data.cur_y) - DX_W'(wa_q.cur_y);
			end
			S_I_AX: begin
				dt2_q <= prod_q[2*DT_W-1:0];
			end
			S_I_AY: begin
				tx_q <= rnd32[TX_W+31:32];
			end
			S_I_NEW: begin
				nx_q  <= int_nx.val;
				ny_q  <= int_ny.val;
				sat_q <= sat_q | int_nx.sat | int_ny.sat;
			end
			S_I_WR: begin
				res_x_q  <= nx_q;
				res_y_q  <= ny_q;
				res_st_q <= (sat_q || (bounce && bnc_oy.sat)) ? ST_SAT : ST_OK;
			end
			S_R_SQY: begin
				sq_q <= prod_q[SQ_W-1:0];
			end
			S_R_SQRT: begin
				if (sqrt_done && root == '0) begin
					res_st_q <= ST_ZERO_LEN;
				end
			end
			S_R_DIFF: begin
				diff_q <= $signed(DIFF_W'(len_q)) - $signed(DIFF_W'(root));
			end
			S_R_NY: begin
				numx_q <= prod_q[NUM_W-1:0];
			end
			S_R_KY: begin
				offx_q <= off_c;
			end
			S_R_OFF: begin
				offy_q <= off_c;
			end
			S_R_WA: begin
				if (!wa_q.pinned) begin
					wa_q.cur_x <= rel_ax.val;
					wa_q.cur_y <= rel_ay.val;
					sat_q      <= sat_q | rel_ax.sat | rel_ay.sat;
				end
			end
			S_R_WB: begin
				res_x_q  <= wa_q.cur_x;
				res_y_q  <= wa_q.cur_y;
				res_st_q <= (sat_q || (!wb_q.pinned && (rel_bx.sat || rel_by.sat))) ?
					ST_SAT : ST_OK;
			end
			default: begin
			end
		endcase
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || rsp.ready)) begin
			out_x_q  <= res_x_q;
			out_y_q  <= res_y_q;
			out_st_q <= res_st_q;
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = out_valid_q;
	assign rsp.pos_x  = out_x_q;
	assign rsp.pos_y  = out_y_q;
	assign rsp.status = out_st_q;

	vpss_mem #(
		.DEPTH  (PARTICLE_COUNT),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	vpss_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sq_q + prod_q[SQ_W-1:0]),
		.done     (sqrt_done),
		.root     (root)
	);

	vpss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_x  (numx_q),
		.num_y  (prod_q[NUM_W-1:0]),
		.den    (root),
		.done   (div_done),
		.quo_x  (quo_x),
		.quo_y  (quo_y)
	);

endmodule

>>> src/vpss_checker.sv
// Port checker of the solver and its bind to the top level.
module vpss_checker import vpss_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_ready,
	input logic                    rsp_valid,
	input logic                    rsp_ready,
	input logic signed [POS_W-1:0] rsp_pos_x,
	input logic signed [POS_W-1:0] rsp_pos_y,
	input logic [STATUS_W-1:0]     rsp_status
);

	// A stalled result transaction keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
			&& $stable(rsp_status))
		else $error("result changed while stalled");

	// Commands are worked one at a time: after a request transaction the block is busy.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a command is in flight");

	// Even the shortest command, a load, passes through S_LOAD and S_DONE before the block is ready again.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> ##1 !req_ready)
		else $error("command finished too early");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_ZERO_LEN
			|| rsp_status == ST_SAT)
		else $error("undefined status code");

endmodule

bind verlet_particle_stick_solver_unit vpss_checker u_vpss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_pos_x  (rsp.pos_x),
	.rsp_pos_y  (rsp.pos_y),
	.rsp_status (rsp.status)
);
